// ===== rtl/core/mtf_pkg.sv =====
// ----------------------------------------------------------------------------
// Move-to-front list package
// Shared widths, opcodes and the cell control record.
// ----------------------------------------------------------------------------
package mtf_pkg;

  localparam int MTF_DEPTH = 16;
  localparam int OPC_W     = 2;
  localparam int VAL_W     = 32;
  localparam int IDX_W     = 4;
  localparam int POS_W     = 4;
  localparam int LCNT_W    = 5;

  typedef enum logic [OPC_W-1:0] {
    OP_APPEND = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_READ   = 2'd2,
    OP_NOP    = 2'd3
  } opcode_t;

  typedef struct packed {
    logic live;   // position holds a valid entry
    logic shift;  // take the neighbour's value
    logic load;   // take the key (append at tail)
  } mtf_cell_ctrl_t;

endpackage

// ===== rtl/core/mtf_if.sv =====
// ----------------------------------------------------------------------------
// Move-to-front list channels
// Valid/ready interfaces for the request and result streams.
// ----------------------------------------------------------------------------
interface mtf_in_if import mtf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OPC_W-1:0]        opcode;
  logic signed [VAL_W-1:0] value;
  logic [IDX_W-1:0]        index;

  modport source (output valid, output opcode, output value, output index, input ready);
  modport sink   (input valid, input opcode, input value, input index, output ready);
endinterface

interface mtf_out_if import mtf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] read_value;
  logic [LCNT_W-1:0]       list_count;
  logic                    dropped;

  modport source (output valid, output hit, output position, output read_value,
                  output list_count, output dropped, input ready);
  modport sink   (input valid, input hit, input position, input read_value,
                  input list_count, input dropped, output ready);
endinterface

// ===== rtl/core/mtf_cell.sv =====
// ----------------------------------------------------------------------------
// Move-to-front list cell
// Holds one entry, compares it with the key and shifts from its neighbour.
// ----------------------------------------------------------------------------
module mtf_cell import mtf_pkg::*; (
  input  logic                    clk,
  input  mtf_cell_ctrl_t          ctrl,
  input  logic signed [VAL_W-1:0] key,
  input  logic signed [VAL_W-1:0] prev_value,
  output logic signed [VAL_W-1:0] value,
  output logic                    match
);

  logic signed [VAL_W-1:0] value_r;
  logic signed [VAL_W-1:0] value_nxt;

  always_comb begin
    value_nxt = value_r;
    if (ctrl.shift) begin
      value_nxt = prev_value;
    end else if (ctrl.load) begin
      value_nxt = key;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;
  assign match = ctrl.live && (value_r == key);

endmodule

// ===== rtl/core/move_to_front_list_top.sv =====
// Latency: a result is valid in the cycle after its request transfer.
// Throughput: one request per cycle unless stalled; all cells compare at once.
// A new request is taken while the result register drains (out ready high).
// Reset: entry count and result valid cleared; entry values are undefined
// until written and need no clearing pass.
// ----------------------------------------------------------------------------
// Move-to-front list top level
// Row of entry cells with a fill count, lookup priority and result register.
// ----------------------------------------------------------------------------
module move_to_front_list_top import mtf_pkg::*; #(
  parameter int DEPTH = MTF_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  mtf_in_if.sink      in_ch,
  mtf_out_if.source   out_ch
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int RD_N  = (DEPTH < (1 << IDX_W)) ? DEPTH : (1 << IDX_W);

  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;
  logic                    out_valid_r;
  logic                    hit_r;
  logic [POS_W-1:0]        pos_r;
  logic signed [VAL_W-1:0] rd_r;
  logic [LCNT_W-1:0]       lcnt_r;
  logic                    drop_r;

  logic                    accept;
  logic                    is_append;
  logic                    is_lookup;
  logic                    is_read;
  logic                    full;
  logic                    any_match;
  logic                    rd_hit;
  logic signed [VAL_W-1:0] rd_val;
  logic [POS_W-1:0]        first_pos;

  logic signed [VAL_W-1:0] cell_val   [DEPTH];
  logic [DEPTH-1:0]        match_v;
  logic [DEPTH-1:0]        seen_v;
  mtf_cell_ctrl_t          cell_ctrl  [DEPTH];

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign is_append = (in_ch.opcode == OP_APPEND);
  assign is_lookup = (in_ch.opcode == OP_LOOKUP);
  assign is_read   = (in_ch.opcode == OP_READ);
  assign full      = (count_r == CNT_W'(DEPTH));
  assign any_match = |match_v;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_head
        assign seen_v[g] = 1'b0;
        mtf_cell u_cell (
          .clk        (clk),
          .ctrl       (cell_ctrl[g]),
          .key        (in_ch.value),
          .prev_value (in_ch.value),
          .value      (cell_val[g]),
          .match      (match_v[g])
        );
      end else begin : g_body
        assign seen_v[g] = |match_v[g-1:0];
        mtf_cell u_cell (
          .clk        (clk),
          .ctrl       (cell_ctrl[g]),
          .key        (in_ch.value),
          .prev_value (cell_val[g-1]),
          .value      (cell_val[g]),
          .match      (match_v[g])
        );
      end

      assign cell_ctrl[g].live  = (CNT_W'(g) < count_r);
      assign cell_ctrl[g].shift = accept && is_lookup && any_match && !seen_v[g];
      assign cell_ctrl[g].load  = accept && is_append && (count_r == CNT_W'(g));
    end
  endgenerate

  always_comb begin
    first_pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (match_v[i] && !seen_v[i]) begin
        first_pos = first_pos | POS_W'(i);
      end
    end
  end

  always_comb begin
    rd_hit = 1'b0;
    rd_val = '0;
    for (int i = 0; i < RD_N; i++) begin
      if ((in_ch.index == IDX_W'(i)) && cell_ctrl[i].live) begin
        rd_hit = 1'b1;
        rd_val = cell_val[i];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (accept && is_append && !full) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hit_r  <= (is_lookup && any_match) || (is_read && rd_hit);
      pos_r  <= (is_lookup && any_match) ? first_pos : '0;
      rd_r   <= (is_read && rd_hit) ? rd_val : '0;
      lcnt_r <= LCNT_W'(count_nxt);
      drop_r <= is_append && full;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.hit        = hit_r;
  assign out_ch.position   = pos_r;
  assign out_ch.read_value = rd_r;
  assign out_ch.list_count = lcnt_r;
  assign out_ch.dropped    = drop_r;

endmodule

// ===== tb/move_to_front_list_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Move-to-front list testbench
// Drives append, lookup, read and idle requests into the list. A shadow
// copy of the ordered list predicts every result, which is checked field by
// field as it transfers. Random gaps on both channels; one long output stall
// and two full drains.
// ----------------------------------------------------------------------------
module move_to_front_list_top_tb;
  import mtf_pkg::*;

  typedef struct packed {
    logic                    hit;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] read_value;
    logic [LCNT_W-1:0]       list_count;
    logic                    dropped;
  } mtf_result_t;

  class mtf_order_tracker;
    logic signed [VAL_W-1:0] cells[MTF_DEPTH];
    int                      fill;
    mtf_result_t             pending_results[$];
    int                      mismatches;

    function new();
      fill       = 0;
      mismatches = 0;
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    // a key already in the list, so that lookups mostly hit
    function logic signed [VAL_W-1:0] stored_key();
      return cells[$urandom_range(0, fill - 1)];
    endfunction

    function void take_request(opcode_t op, logic signed [VAL_W-1:0] val,
                               logic [IDX_W-1:0] idx);
      mtf_result_t r;
      int          found;
      r     = '0;
      found = -1;
      case (op)
        OP_APPEND: begin
          if (fill < MTF_DEPTH) begin
            cells[fill] = val;
            fill++;
          end else begin
            r.dropped = 1'b1;
          end
        end
        OP_LOOKUP: begin
          for (int i = 0; i < fill; i++)
            if (found < 0 && cells[i] == val) found = i;
          if (found >= 0) begin
            r.hit      = 1'b1;
            r.position = POS_W'(found);
            for (int j = found; j > 0; j--) cells[j] = cells[j-1];
            cells[0] = val;
          end
        end
        OP_READ: begin
          if (int'(idx) < fill) begin
            r.hit        = 1'b1;
            r.read_value = cells[idx];
          end
        end
        default: ;
      endcase
      r.list_count = LCNT_W'(fill);
      pending_results.push_back(r);
    endfunction

    function void check_field(string label, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 40)
          $display("%0t: %s expected %0h, actual %0h", $time, label, want, got);
      end
    endfunction

    function void compare_result(mtf_result_t got);
      mtf_result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 40)
          $display("%0t: unexpected result expected none, actual %0h", $time, got);
        return;
      end
      want = pending_results.pop_front();
      check_field("hit", VAL_W'(want.hit), VAL_W'(got.hit));
      check_field("position", VAL_W'(want.position), VAL_W'(got.position));
      check_field("read_value", want.read_value, got.read_value);
      check_field("list_count", VAL_W'(want.list_count), VAL_W'(got.list_count));
      check_field("dropped", VAL_W'(want.dropped), VAL_W'(got.dropped));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  bit calm;       // no idling on either side
  bit tx_steady;  // sender offers back to back
  bit stall_rx;   // ask the receiver for one long hold-off

  mtf_order_tracker tracker;

  mtf_in_if  in_ch();
  mtf_out_if out_ch();

  move_to_front_list_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      tracker.compare_result({out_ch.hit, out_ch.position, out_ch.read_value,
                              out_ch.list_count, out_ch.dropped});
  end

  initial begin : receiver
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (stall_rx) begin
        stall_rx = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (64) @(negedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  end

  task automatic send_request(input opcode_t op, input logic signed [VAL_W-1:0] val,
                              input logic [IDX_W-1:0] idx);
    if (!calm && !tx_steady && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.opcode <= op;
    in_ch.value  <= val;
    in_ch.index  <= idx;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    tracker.take_request(op, val, idx);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (tracker.outstanding() != 0);
  endtask

  function automatic logic signed [VAL_W-1:0] any_value();
    case ($urandom_range(0, 7))
      0:       return 32'sh0;
      1:       return -32'sd1;
      2:       return 32'sh8000_0000;
      3:       return 32'sh7fff_ffff;
      4:       return 32'(signed'($urandom_range(0, 5)));
      default: return $urandom;
    endcase
  endfunction

  task automatic random_request();
    int                      pick;
    logic signed [VAL_W-1:0] val;
    logic [IDX_W-1:0]        idx;
    pick = $urandom_range(0, 99);
    val  = any_value();
    idx  = IDX_W'($urandom_range(0, 15));
    if (pick < 20) begin
      send_request(OP_APPEND, val, idx);
    end else if (pick < 65) begin
      if (tracker.fill > 0 && $urandom_range(0, 3) != 0) val = tracker.stored_key();
      send_request(OP_LOOKUP, val, idx);
    end else if (pick < 90) begin
      send_request(OP_READ, val, idx);
    end else begin
      send_request(OP_NOP, val, idx);
    end
  endtask

  initial begin
    tracker      = new();
    calm         = 1'b0;
    tx_steady    = 1'b0;
    stall_rx     = 1'b0;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.opcode = OP_NOP;
    in_ch.value  = '0;
    in_ch.index  = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty list
    send_request(OP_READ, 32'sh0, 4'd0);
    send_request(OP_READ, -32'sd1, 4'd15);
    send_request(OP_LOOKUP, 32'sh0, 4'd0);
    send_request(OP_NOP, 32'sh0, 4'd0);
    // fill with extremes and a duplicate
    send_request(OP_APPEND, 32'sh8000_0000, 4'd0);
    send_request(OP_APPEND, 32'sh7fff_ffff, 4'd15);
    send_request(OP_APPEND, 32'sh0, 4'd0);
    send_request(OP_APPEND, -32'sd1, 4'd0);
    send_request(OP_APPEND, 32'sd5, 4'd0);
    send_request(OP_APPEND, 32'sh0, 4'd0);
    // frontmost duplicate moves, then a hit at the front
    send_request(OP_LOOKUP, 32'sh0, 4'd0);
    send_request(OP_LOOKUP, 32'sh0, 4'd0);
    send_request(OP_LOOKUP, 32'sd5, 4'd0);
    // hit at the tail
    send_request(OP_APPEND, 32'sd7, 4'd0);
    send_request(OP_LOOKUP, 32'sd7, 4'd0);
    send_request(OP_LOOKUP, 32'sd12345, 4'd0);
    send_request(OP_LOOKUP, 32'sh8000_0000, 4'd0);
    send_request(OP_READ, 32'sh0, 4'd0);
    send_request(OP_READ, 32'sh0, 4'd6);
    send_request(OP_READ, 32'sh0, 4'd7);
    send_request(OP_READ, 32'sh0, 4'd15);
    send_request(OP_NOP, -32'sd1, 4'd15);

    for (int n = 0; n < 1050; n++) begin
      if (n == 300) begin
        stall_rx  = 1'b1;
        tx_steady = 1'b1;
      end
      if (n == 340) tx_steady = 1'b0;
      if (n == 600) wait_drained();
      if (n == 900) calm = 1'b1;
      random_request();
    end

    wait_drained();
    repeat (8) @(negedge clk);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/mtf_pkg.sv
rtl/core/mtf_if.sv
rtl/core/mtf_cell.sv
rtl/core/move_to_front_list_top.sv
tb/move_to_front_list_top_tb.sv
